FILE: hw/rtl/glob_permission_matcher_unit_assert.svh
// Assertion macros used by the matcher RTL.
`ifndef GLOB_PERMISSION_MATCHER_UNIT_ASSERT_SVH
`define GLOB_PERMISSION_MATCHER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GPM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/gpm_pkg.sv
package gpm_pkg;

    // Pattern geometry.
    localparam int MAX_PATTERN_BYTES = 32;
    localparam int POS_W             = MAX_PATTERN_BYTES + 1;
    localparam int LEN_W             = $clog2(POS_W);
    localparam int PAT_W             = 8 * MAX_PATTERN_BYTES;
    localparam int CLOSURE_STEPS     = $clog2(POS_W);

    // Register file geometry and field widths.
    localparam int WORD_W     = 64;
    localparam int ADDR_W     = 6;
    localparam int RAW_LEN_W  = 6;
    localparam int TYPE_W     = 4;
    localparam int ACTION_W   = 2;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 8;

    // Special bytes and codes.
    localparam logic [7:0]          STAR_BYTE   = 8'h2A;
    localparam logic [7:0]          QMARK_BYTE  = 8'h3F;
    localparam logic [TYPE_W-1:0]   ADMIN_TYPE  = 4'hF;
    localparam logic [ACTION_W-1:0] DENY_ACTION = 2'd1;

    typedef enum logic [2:0] {
        REG_WORD0  = 3'd0,
        REG_WORD1  = 3'd1,
        REG_WORD2  = 3'd2,
        REG_WORD3  = 3'd3,
        REG_LENGTH = 3'd4,
        REG_TYPE   = 3'd5,
        REG_ACTION = 3'd6
    } t_reg_idx;

    typedef logic [POS_W-1:0] t_pos;

    localparam t_pos POS_INIT = t_pos'(1);

    typedef struct packed {
        logic [PAT_W-1:0]    pattern;
        logic [LEN_W-1:0]    length;
        logic [TYPE_W-1:0]   rule_type;
        logic [ACTION_W-1:0] rule_action;
    } t_cfg;

    typedef struct packed {
        logic [7:0]        ch;
        logic              has_char;
        logic [TYPE_W-1:0] query_type;
        logic              last;
    } t_item;

    typedef struct packed {
        t_pos              positions;
        logic [TYPE_W-1:0] query_type;
    } t_fin;

    // Bit j is set when position j is reached from position j-1 across a star.
    function automatic t_pos star_prop(logic [PAT_W-1:0] pattern, logic [LEN_W-1:0] length);
        t_pos prop;
        prop = '0;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
            prop[i+1] = (pattern[8*i +: 8] == STAR_BYTE) && (LEN_W'(i) < length);
        end
        return prop;
    endfunction

    // Star closure as a parallel prefix, in the manner of a carry chain.
    function automatic t_pos star_closure(t_pos set, t_pos prop);
        t_pos a;
        t_pos p;
        a = set;
        p = prop;
        for (int k = 0; k < CLOSURE_STEPS; k++) begin
            a = a | (p & (a << (1 << k)));
            p = p & (p << (1 << k));
        end
        return a;
    endfunction

endpackage

FILE: hw/rtl/gpm_cfg_regs.sv
module gpm_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [gpm_pkg::ADDR_W-1:0] paddr,
    input  logic [gpm_pkg::WORD_W-1:0] pwdata,
    output logic [gpm_pkg::WORD_W-1:0] prdata,
    output logic                       pready,
    output gpm_pkg::t_cfg              o_cfg
);
    import gpm_pkg::*;

    logic [PAT_W-1:0]     r_pattern;
    logic [RAW_LEN_W-1:0] r_length;
    logic [TYPE_W-1:0]    r_type;
    logic [ACTION_W-1:0]  r_action;
    t_reg_idx             reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:3]);
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes; the index with no register is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_length  <= '0;
            r_type    <= '0;
            r_action  <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_WORD0:  r_pattern[0*WORD_W +: WORD_W] <= pwdata;
                REG_WORD1:  r_pattern[1*WORD_W +: WORD_W] <= pwdata;
                REG_WORD2:  r_pattern[2*WORD_W +: WORD_W] <= pwdata;
                REG_WORD3:  r_pattern[3*WORD_W +: WORD_W] <= pwdata;
                REG_LENGTH: r_length <= pwdata[RAW_LEN_W-1:0];
                REG_TYPE:   r_type   <= pwdata[TYPE_W-1:0];
                REG_ACTION: r_action <= pwdata[ACTION_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        unique case (reg_idx)
            REG_WORD0:  prdata = r_pattern[0*WORD_W +: WORD_W];
            REG_WORD1:  prdata = r_pattern[1*WORD_W +: WORD_W];
            REG_WORD2:  prdata = r_pattern[2*WORD_W +: WORD_W];
            REG_WORD3:  prdata = r_pattern[3*WORD_W +: WORD_W];
            REG_LENGTH: prdata = WORD_W'(r_length);
            REG_TYPE:   prdata = WORD_W'(r_type);
            REG_ACTION: prdata = WORD_W'(r_action);
            default:    prdata = '0;
        endcase
    end

    // The length used by the matcher is saturated to the pattern capacity.
    always_comb begin
        o_cfg.pattern     = r_pattern;
        o_cfg.rule_type   = r_type;
        o_cfg.rule_action = r_action;
        if (32'(r_length) > 32'(MAX_PATTERN_BYTES)) begin
            o_cfg.length = LEN_W'(MAX_PATTERN_BYTES);
        end else begin
            o_cfg.length = LEN_W'(r_length);
        end
    end

endmodule

FILE: hw/rtl/gpm_step.sv
module gpm_step (
    input  gpm_pkg::t_cfg  i_cfg,
    input  gpm_pkg::t_pos  i_active,
    input  gpm_pkg::t_item i_item,
    output gpm_pkg::t_pos  o_positions
);
    import gpm_pkg::*;

    t_pos cur;
    t_pos stepped;

    // Close the held set over stars, then step each position on one byte: a star keeps its place, a match advances.
    always_comb begin
        logic [7:0] pbyte;
        logic       in_len;
        logic       is_star;
        cur     = star_closure(i_active, star_prop(i_cfg.pattern, i_cfg.length));
        stepped = '0;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
            pbyte   = i_cfg.pattern[8*i +: 8];
            in_len  = LEN_W'(i) < i_cfg.length;
            is_star = pbyte == STAR_BYTE;
            if (cur[i] && in_len && is_star) begin
                stepped[i] = 1'b1;
            end
            if (cur[i] && in_len && !is_star
                && ((pbyte == QMARK_BYTE) || (pbyte == i_item.ch))) begin
                stepped[i+1] = 1'b1;
            end
        end
    end

    // An item without a byte leaves the set as it is.
    assign o_positions = i_item.has_char ? stepped : i_active;

endmodule

FILE: hw/rtl/gpm_verdict.sv
module gpm_verdict (
    input  gpm_pkg::t_cfg i_cfg,
    input  gpm_pkg::t_fin i_fin,
    output logic          o_implied,
    output logic          o_matched
);
    import gpm_pkg::*;

    t_pos closed;

    // The target matched when the end of the pattern is reachable.
    assign closed    = star_closure(i_fin.positions, star_prop(i_cfg.pattern, i_cfg.length));
    assign o_matched = closed[i_cfg.length];

    // A deny rule never implies; otherwise an admin rule always does.
    always_comb begin
        if (i_cfg.rule_action == DENY_ACTION) begin
            o_implied = 1'b0;
        end else if (i_cfg.rule_type == ADMIN_TYPE) begin
            o_implied = 1'b1;
        end else begin
            o_implied = (i_cfg.rule_type == i_fin.query_type) && o_matched;
        end
    end

endmodule

FILE: hw/rtl/glob_permission_matcher_unit.sv
// Glob permission matcher: one target byte per item, one result per target.
// Throughput: one item per cycle unless results stall, set by the position-set update loop.
// Pipeline: three register stages; a last item passes the input, final and output
// registers in turn, and its result is valid once it sits in the output register.
// Reset (synchronous, active low) empties the pipeline, returns the position set
// to position zero and clears all configuration registers to zero.
`include "glob_permission_matcher_unit_assert.svh"

module glob_permission_matcher_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // APB configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gpm_pkg::ADDR_W-1:0]     paddr,
    input  logic [gpm_pkg::WORD_W-1:0]     pwdata,
    output logic [gpm_pkg::WORD_W-1:0]     prdata,
    output logic                           pready,
    // Target stream in
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [gpm_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // ch[7:0], query_type[11:8], zeros
    input  logic [0:0]                     s_axis_tuser,  // has_char[0]
    input  logic                           s_axis_tlast,
    // Result stream out
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [gpm_pkg::OUT_DATA_W-1:0] m_axis_tdata   // implied[0], target_matched[1], zeros
);
    import gpm_pkg::*;

    t_cfg  cfg;
    t_item r_in;
    logic  r_in_valid;
    t_pos  r_active;
    t_pos  n_positions;
    t_fin  r_fin;
    logic  r_fin_valid;
    logic  r_out_valid;
    logic  r_out_implied;
    logic  r_out_matched;
    logic  fin_implied;
    logic  fin_matched;
    logic  en_in;
    logic  en_fin;
    logic  en_out;

    gpm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    gpm_step u_step (
        .i_cfg       (cfg),
        .i_active    (r_active),
        .i_item      (r_in),
        .o_positions (n_positions)
    );

    gpm_verdict u_verdict (
        .i_cfg     (cfg),
        .i_fin     (r_fin),
        .o_implied (fin_implied),
        .o_matched (fin_matched)
    );

    // Each stage advances when the stage after it has room.
    assign en_out        = !r_out_valid || m_axis_tready;
    assign en_fin        = !r_fin_valid || en_out;
    assign en_in         = !r_in_valid || en_fin;
    assign s_axis_tready = en_in;

    // Pipeline control and the position set.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_fin_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_active    <= POS_INIT;
        end else begin
            if (en_in) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (en_fin) begin
                r_fin_valid <= r_in_valid && r_in.last;
            end
            if (en_out) begin
                r_out_valid <= r_fin_valid;
            end
            if (r_in_valid && en_fin) begin
                r_active <= r_in.last ? POS_INIT : n_positions;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (en_in && s_axis_tvalid) begin
            r_in.ch         <= s_axis_tdata[7:0];
            r_in.query_type <= s_axis_tdata[8 +: TYPE_W];
            r_in.has_char   <= s_axis_tuser[0];
            r_in.last       <= s_axis_tlast;
        end
        if (en_fin && r_in_valid && r_in.last) begin
            r_fin.positions  <= n_positions;
            r_fin.query_type <= r_in.query_type;
        end
        if (en_out && r_fin_valid) begin
            r_out_implied <= fin_implied;
            r_out_matched <= fin_matched;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-2){1'b0}}, r_out_matched, r_out_implied};

    // A finished target always leaves a fresh position set behind.
    `GPM_ASSERT_NEXT(a_active_reinit, i_clk, i_rst_n,
        r_in_valid && en_fin && r_in.last, r_active == POS_INIT,
        "position set not reset after last item")
    // A stalled final stage keeps its item.
    `GPM_ASSERT_NEXT(a_fin_hold, i_clk, i_rst_n,
        r_fin_valid && !en_out, r_fin_valid && $stable(r_fin.positions),
        "final stage lost its item under stall")
    // An item that is not last never reaches the final stage.
    `GPM_ASSERT_NEXT(a_fin_only_last, i_clk, i_rst_n,
        r_in_valid && en_fin && !r_in.last, !r_fin_valid,
        "non-last item produced a result")
    // An empty input stage can always take an item.
    `GPM_ASSERT_SAME(a_ready_empty, i_clk, i_rst_n,
        !r_in_valid, s_axis_tready,
        "input stage empty but not ready")

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import gpm_pkg::*;

    localparam int          HALF_PERIOD    = 2;
    localparam int          RESET_CYCLES   = 7;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          RANDOM_ITEMS   = 2000;
    localparam longint      RUN_LIMIT_NS   = 2000000;
    localparam logic [2:0]  UNMAPPED_REG   = 3'd7;
    localparam logic [1:0]  ACT_GRANT      = 2'd0;
    localparam logic [1:0]  ACT_REVOKE     = 2'd2;
    localparam logic [1:0]  ACT_UNUSED     = 2'd3;

    typedef struct packed {
        logic implied;
        logic matched;
    } t_verdict;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_PATTERN,
        RX_CHOKED
    } t_rx_mode;

    // Tracks the rule registers and the live position set, and holds the
    // verdicts still owed by the block.
    class verdict_tracker;
        logic [63:0] words[4];
        logic [5:0]  raw_len;
        logic [3:0]  rtype;
        logic [1:0]  action;
        t_pos        live;
        t_verdict    due[$];
        int unsigned errors;
        int unsigned seen;

        function new();
            for (int w = 0; w < 4; w++) words[w] = '0;
            raw_len = '0;
            rtype   = '0;
            action  = '0;
            live    = POS_INIT;
            errors  = 0;
            seen    = 0;
        endfunction

        function void configure(logic [2:0] idx, logic [63:0] value);
            case (idx)
                REG_WORD0, REG_WORD1, REG_WORD2, REG_WORD3: words[idx[1:0]] = value;
                REG_LENGTH: raw_len = value[5:0];
                REG_TYPE:   rtype   = value[3:0];
                REG_ACTION: action  = value[1:0];
                default: ;
            endcase
        endfunction

        function int pattern_len();
            return (raw_len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : int'(raw_len);
        endfunction

        function logic [7:0] pattern_byte(int k);
            return words[k / 8][8 * (k % 8) +: 8];
        endfunction

        // A star position passes its activity on to the following position.
        function t_pos spread_stars(t_pos s, int n);
            t_pos r;
            r = s;
            for (int i = 0; i < n; i++)
                if (r[i] && pattern_byte(i) == STAR_BYTE) r[i + 1] = 1'b1;
            return r;
        endfunction

        function void take_item(t_item it);
            t_pos     cur;
            t_pos     nxt;
            int       n;
            t_verdict v;
            n = pattern_len();
            if (it.has_char) begin
                cur = spread_stars(live, n);
                nxt = '0;
                for (int i = 0; i < n; i++) begin
                    if (cur[i]) begin
                        if (pattern_byte(i) == STAR_BYTE)
                            nxt[i] = 1'b1;
                        else if (pattern_byte(i) == QMARK_BYTE || pattern_byte(i) == it.ch)
                            nxt[i + 1] = 1'b1;
                    end
                end
                live = nxt;
            end
            if (it.last) begin
                cur = spread_stars(live, n);
                v.matched = cur[n];
                if (action == DENY_ACTION)
                    v.implied = 1'b0;
                else if (rtype == ADMIN_TYPE)
                    v.implied = 1'b1;
                else
                    v.implied = (rtype == it.query_type) && v.matched;
                due.insert(due.size(), v);
                live = POS_INIT;
            end
        endfunction

        function int pending();
            return due.size();
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_verdict(logic implied, logic matched);
            t_verdict want;
            seen++;
            if (due.size() == 0) begin
                report($sformatf("result %0d arrived with nothing owed (implied %0b matched %0b)",
                                 seen, implied, matched));
                return;
            end
            want = due.pop_front();
            if (matched !== want.matched)
                report($sformatf("result %0d target_matched %0b, expected %0b",
                                 seen, matched, want.matched));
            if (implied !== want.implied)
                report($sformatf("result %0d implied %0b, expected %0b",
                                 seen, implied, want.implied));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [WORD_W-1:0]     pwdata;
    logic [WORD_W-1:0]     prdata;
    logic                  pready;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // ch[7:0], query_type[11:8], zeros
    logic [0:0]            s_axis_tuser;   // has_char[0]
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // implied[0], target_matched[1], zeros

    verdict_tracker board;

    // Sender state and a mirror of the rule, used to shape targets.
    logic [7:0]    target[$];
    int unsigned   items_sent;
    int unsigned   burst_left;
    bit            tx_calm;
    logic [255:0]  gen_pat;
    int            gen_len;
    logic [3:0]    gen_type;

    // Receiver state; a long hold is requested by bumping hold_asked.
    int unsigned   hold_asked  = 0;
    int unsigned   hold_served = 0;
    int unsigned   hold_left   = 0;
    int unsigned   rx_left     = 0;
    logic [7:0]    rx_tick     = '0;
    t_rx_mode      rx_mode     = RX_OPEN;

    glob_permission_matcher_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Result side: a long hold when asked, otherwise a changing stall pattern.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_served != hold_asked) begin
            m_axis_tready <= 1'b0;
            hold_served   <= hold_asked;
            hold_left     <= HOLD_CYCLES;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= t_rx_mode'($urandom_range(0, 3));
                rx_left <= $urandom_range(16, 160);
            end else begin
                rx_left <= rx_left - 1;
            end
            rx_tick <= rx_tick + 8'd1;
            case (rx_mode)
                RX_OPEN:    m_axis_tready <= 1'b1;
                RX_RANDOM:  m_axis_tready <= ($urandom_range(0, 99) < 65);
                RX_PATTERN: m_axis_tready <= (rx_tick[2:0] < 3'd5);
                default:    m_axis_tready <= ($urandom_range(0, 99) < 20);
            endcase
        end
    end

    // Every accepted result is checked against the oldest owed verdict.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_verdict(m_axis_tdata[0], m_axis_tdata[1]);
    end

    // Register write: setup phase, access phase, then an idle gap with psel low.
    task automatic apb_write(input logic [2:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.configure(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // Write the whole rule; unused upper bits of the narrow fields carry junk.
    task automatic load_rule(input logic [255:0] pat, input logic [5:0] len,
                             input logic [3:0] rtype, input logic [1:0] act);
        apb_write(REG_WORD0, pat[63:0]);
        apb_write(REG_WORD1, pat[127:64]);
        apb_write(REG_WORD2, pat[191:128]);
        apb_write(REG_WORD3, pat[255:192]);
        apb_write(REG_LENGTH, ({$urandom, $urandom} & ~64'h3F) | 64'(len));
        apb_write(REG_TYPE, ({$urandom, $urandom} & ~64'hF) | 64'(rtype));
        apb_write(REG_ACTION, ({$urandom, $urandom} & ~64'h3) | 64'(act));
        gen_pat  = pat;
        gen_len  = (len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : int'(len);
        gen_type = rtype;
    endtask

    task automatic idle_for(input int unsigned n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // Offer one item, in bursts with random gaps unless the sender runs calm.
    task automatic send_item(input t_item it);
        if (!tx_calm) begin
            if (burst_left == 0) begin
                idle_for($urandom_range(1, 8));
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, it.query_type, it.ch};
        s_axis_tuser  <= it.has_char;
        s_axis_tlast  <= it.last;
        do @(posedge i_clk); while (!s_axis_tready);
        board.take_item(it);
        if (it.has_char || it.last) items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_noise();
        t_item it;
        it.ch         = 8'($urandom);
        it.has_char   = 1'b0;
        it.query_type = 4'($urandom);
        it.last       = 1'b0;
        send_item(it);
    endtask

    // Send the bytes in target, closing with an empty last item if asked or if target is empty.
    task automatic send_target(input logic [3:0] qtype, input bit tail_empty, input bit noisy);
        t_item it;
        int    n;
        n = target.size();
        for (int i = 0; i < n; i++) begin
            if (noisy && $urandom_range(0, 99) < 8) send_noise();
            it.ch         = target[i];
            it.has_char   = 1'b1;
            it.last       = (i == n - 1) && !tail_empty;
            it.query_type = it.last ? qtype : 4'($urandom);
            send_item(it);
        end
        if (n == 0 || tail_empty) begin
            it.ch         = 8'($urandom);
            it.has_char   = 1'b0;
            it.last       = 1'b1;
            it.query_type = qtype;
            send_item(it);
        end
    endtask

    // Wait until every owed verdict has come, then let the pipeline settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic load_text(input string s);
        target.delete();
        for (int i = 0; i < s.len(); i++) target.insert(target.size(), s[i]);
    endtask

    function automatic logic [255:0] pack_text(input string s);
        logic [255:0] r;
        r = '0;
        for (int i = 0; i < s.len() && i < 32; i++) r[8 * i +: 8] = s[i];
        return r;
    endfunction

    function automatic logic [7:0] pick_pattern_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return STAR_BYTE;
        if (r < 55) return QMARK_BYTE;
        if (r < 90) return 8'("a" + $urandom_range(0, 2));
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] pick_text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return 8'("a" + $urandom_range(0, 2));
        if (r < 88) return STAR_BYTE;
        if (r < 93) return QMARK_BYTE;
        return 8'($urandom);
    endfunction

    // Mostly pattern-shaped targets, some damaged, the rest noise; brief: at most one byte.
    task automatic build_target(input bit brief);
        logic [7:0] b;
        int         at;
        target.delete();
        if (brief) begin
            repeat ($urandom_range(0, 1)) target.insert(target.size(), pick_text_byte());
        end else if ($urandom_range(0, 99) < 75) begin
            for (int k = 0; k < gen_len; k++) begin
                b = gen_pat[8 * k +: 8];
                if (b == STAR_BYTE)
                    repeat ($urandom_range(0, 3)) target.insert(target.size(), pick_text_byte());
                else if (b == QMARK_BYTE)
                    target.insert(target.size(), pick_text_byte());
                else
                    target.insert(target.size(), b);
            end
            if (target.size() > 0 && $urandom_range(0, 99) < 30) begin
                at = $urandom_range(0, target.size() - 1);
                case ($urandom_range(0, 2))
                    0:       target[at] = pick_text_byte();
                    1:       target.delete(at);
                    default: target.insert(at, pick_text_byte());
                endcase
            end
        end else begin
            repeat ($urandom_range(0, 6)) target.insert(target.size(), pick_text_byte());
        end
    endtask

    // A fresh rule per phase; the first two phases take the register extremes.
    task automatic random_rule(input int phase);
        logic [255:0] pat;
        logic [5:0]   len;
        logic [3:0]   rt;
        logic [1:0]   act;
        int           r;
        for (int k = 0; k < 32; k++) pat[8 * k +: 8] = pick_pattern_byte();
        r = $urandom_range(0, 99);
        if (r < 70)      len = 6'($urandom_range(0, 8));
        else if (r < 85) len = 6'($urandom_range(9, 31));
        else if (r < 93) len = 6'd32;
        else             len = 6'($urandom_range(33, 63));
        r = $urandom_range(0, 99);
        if (r < 20)      rt = ADMIN_TYPE;
        else if (r < 30) rt = 4'd0;
        else             rt = 4'($urandom);
        act = ($urandom_range(0, 99) < 60) ? ACT_GRANT : 2'($urandom);
        if (phase == 0) begin
            pat = '1;
            len = 6'd32;
            rt  = 4'd0;
            act = ACT_GRANT;
        end else if (phase == 1) begin
            pat = '0;
            len = 6'd63;
            rt  = 4'd14;
            act = ACT_REVOKE;
        end
        load_rule(pat, len, rt, act);
    endtask

    // Stimulus: reset, directed cases, then random phases with a new rule each.
    initial begin
        int unsigned budget;
        logic [3:0]  qtype;
        board         = new();
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        items_sent    = 0;
        burst_left    = 0;
        tx_calm       = 1'b1;
        gen_pat       = '0;
        gen_len       = 0;
        gen_type      = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty pattern after reset: an empty target matches, a skipped item does nothing.
        target.delete();
        send_target(4'd0, 1'b0, 1'b0);
        send_noise();
        send_target(4'd5, 1'b0, 1'b0);
        drain();

        // Star and question mark, a miss, and a literal star in the target.
        load_rule(pack_text("a*b?"), 6'd4, 4'd3, ACT_GRANT);
        load_text("axxbz");
        send_target(4'd3, 1'b0, 1'b0);
        load_text("ab");
        send_target(4'd3, 1'b0, 1'b0);
        load_text("a*b*");
        send_target(4'd3, 1'b0, 1'b0);
        drain();

        // Extreme byte values under an admin rule, then the same rule denied.
        load_rule({240'd0, 8'hFF, 8'h00}, 6'd2, ADMIN_TYPE, ACT_REVOKE);
        target = '{8'h00, 8'hFF};
        send_target(4'd0, 1'b0, 1'b0);
        drain();
        apb_write(REG_ACTION, 64'(DENY_ACTION));
        send_target(4'd0, 1'b0, 1'b0);
        drain();

        // Length beyond the limit saturates; the unused action code is no deny.
        load_rule({32{STAR_BYTE}}, 6'd63, 4'd0, ACT_UNUSED);
        load_text("q");
        send_target(ADMIN_TYPE, 1'b0, 1'b0);
        load_text("zz");
        send_target(4'd0, 1'b1, 1'b0);
        drain();

        // A write past the last register must leave the rule alone.
        apb_write(UNMAPPED_REG, '1);
        target.delete();
        send_target(4'd0, 1'b0, 1'b0);

        budget = items_sent + RANDOM_ITEMS;
        for (int phase = 0; items_sent < budget; phase++) begin
            drain();
            random_rule(phase);
            tx_calm = ($urandom_range(0, 99) < 25);
            // One phase fills the block against a long receiver hold.
            if (phase == 2) begin
                hold_asked++;
                tx_calm = 1'b1;
            end
            for (int unsigned stop = items_sent + $urandom_range(60, 200);
                 items_sent < stop && items_sent < budget;) begin
                build_target(phase == 2);
                qtype = ($urandom_range(0, 99) < 60) ? gen_type : 4'($urandom);
                send_target(qtype, $urandom_range(0, 99) < 12, 1'b1);
            end
        end
        drain();

        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("timeout with %0d verdicts still owed", board.pending());
        $display("== FAIL ==");
        $finish;
    end

endmodule
